FILE: rtl/core/via_pkg.sv
// Package for the interface adapter core: request kinds, register map,
// flag bit positions, timer maximum, the controller state and command types. No dependencies.
package via_pkg;

	typedef enum logic [2:0] {
		OP_READ = 3'd0,
		OP_WRITE = 3'd1,
		OP_TICK = 3'd2,
		OP_CA1 = 3'd3,
		OP_CA2 = 3'd4,
		OP_CB1 = 3'd5,
		OP_CB2 = 3'd6,
		OP_NONE = 3'd7
	} via_op_t;

	typedef enum logic [3:0] {
		REG_ORB = 4'd0,
		REG_ORA = 4'd1,
		REG_DDRB = 4'd2,
		REG_DDRA = 4'd3,
		REG_T1CL = 4'd4,
		REG_T1CH = 4'd5,
		REG_T1LL = 4'd6,
		REG_T1LH = 4'd7,
		REG_T2CL = 4'd8,
		REG_T2CH = 4'd9,
		REG_SR = 4'd10,
		REG_ACR = 4'd11,
		REG_PCR = 4'd12,
		REG_IFR = 4'd13,
		REG_IER = 4'd14,
		REG_ORA_NH = 4'd15
	} via_reg_t;

	localparam int FLAG_CA2 = 0;
	localparam int FLAG_CA1 = 1;
	localparam int FLAG_SR = 2;
	localparam int FLAG_CB2 = 3;
	localparam int FLAG_CB1 = 4;
	localparam int FLAG_T2 = 5;
	localparam int FLAG_T1 = 6;

	localparam logic [15:0] TIMER_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HOLD
	} via_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic out_load;
	} via_cmd_t;

endpackage

FILE: rtl/core/versatile_interface_adapter_core.sv
// Interface adapter core, top level: controller plus datapath.
// Sequence: request capture, execute, result load into the output register.
// A new request is not accepted until the previous result is loaded, which
// waits while the earlier result is held by out_stall.
// Reset (arst_n low, asynchronous): architectural registers to 6522 power-on
// values, timers 0xFFFF, no result pending; request and result regs not reset.
module versatile_interface_adapter_core import via_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] opcode,
	input logic [3:0] reg_select,
	input logic [7:0] write_data,
	input logic line_level,
	input logic [7:0] port_a_pins,
	input logic [7:0] port_b_pins,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] read_data,
	output logic irq,
	output logic [7:0] port_a_out,
	output logic [7:0] port_b_out,
	output logic pb7_level,
	output logic ca2_level,
	output logic cb2_level
);

	via_cmd_t cmd;

	via_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd)
	);

	via_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.opcode(opcode), .reg_select(reg_select), .write_data(write_data),
		.line_level(line_level), .port_a_pins(port_a_pins), .port_b_pins(port_b_pins),
		.read_data(read_data), .irq(irq), .port_a_out(port_a_out),
		.port_b_out(port_b_out), .pb7_level(pb7_level),
		.ca2_level(ca2_level), .cb2_level(cb2_level)
	);

endmodule

FILE: rtl/core/via_ctrl.sv
// Controller for the interface adapter: sequences capture, execute and
// result delivery. Depends on via_pkg.
module via_ctrl import via_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output via_cmd_t cmd
);

	via_state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Next state: capture, execute, then result into the output register
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = ST_HOLD;
			ST_HOLD: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_EXEC: cmd.exec = 1'b1;
			ST_HOLD: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("exec did not follow load");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q) else $error("result dropped");

endmodule

FILE: rtl/core/via_dp.sv
// Datapath for the interface adapter: register file, timers, flags and
// control lines, plus the result register. Depends on via_pkg.
module via_dp import via_pkg::*; (
	input logic clk,
	input logic arst_n,
	input via_cmd_t cmd,
	input logic [2:0] opcode,
	input logic [3:0] reg_select,
	input logic [7:0] write_data,
	input logic line_level,
	input logic [7:0] port_a_pins,
	input logic [7:0] port_b_pins,
	output logic [7:0] read_data,
	output logic irq,
	output logic [7:0] port_a_out,
	output logic [7:0] port_b_out,
	output logic pb7_level,
	output logic ca2_level,
	output logic cb2_level
);

	// Captured request
	logic [2:0] op_q;
	logic [3:0] rs_q;
	logic [7:0] wd_q, pa_q, pb_q;
	logic lvl_q;

	// Architectural state
	logic [7:0] ora_q, orb_q, ddra_q, ddrb_q;
	logic [15:0] t1c_q, t1l_q, t2c_q;
	logic [7:0] t2ll_q;
	logic t1act_q, t2act_q, pb7_q;
	logic [7:0] sr_q, acr_q, pcr_q;
	logic [6:0] ifr_q, ier_q;
	logic [7:0] lata_q, latb_q;
	logic ca1_q, ca2_q, cb1_q, cb2_q;
	logic [7:0] rd_q;

	// Next values
	logic [7:0] ora_n, orb_n, ddra_n, ddrb_n, sr_n, acr_n, pcr_n, t2ll_n, lata_n, latb_n;
	logic [15:0] t1c_n, t1l_n, t2c_n;
	logic t1act_n, t2act_n, pb7_n;
	logic [6:0] ifr_n, ier_n;
	logic ca1_n, ca2_n, cb1_n, cb2_n;
	logic [7:0] rd_n, in_b, in_a;
	logic [2:0] ca2_ctl, cb2_ctl;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			rs_q <= reg_select;
			wd_q <= write_data;
			lvl_q <= line_level;
			pa_q <= port_a_pins;
			pb_q <= port_b_pins;
		end
	end

	function automatic logic drive(input logic cur, input logic [2:0] mode);
		logic r;
		r = cur;
		if (mode == 3'd5 || mode == 3'd6) r = 1'b0;
		else if (mode == 3'd7) r = 1'b1;
		return r;
	endfunction

	// Request execution
	always_comb begin
		ora_n = ora_q; orb_n = orb_q; ddra_n = ddra_q; ddrb_n = ddrb_q;
		sr_n = sr_q; acr_n = acr_q; pcr_n = pcr_q; t2ll_n = t2ll_q;
		lata_n = lata_q; latb_n = latb_q;
		t1c_n = t1c_q; t1l_n = t1l_q; t2c_n = t2c_q;
		t1act_n = t1act_q; t2act_n = t2act_q; pb7_n = pb7_q;
		ifr_n = ifr_q; ier_n = ier_q;
		ca1_n = ca1_q; ca2_n = ca2_q; cb1_n = cb1_q; cb2_n = cb2_q;
		rd_n = 8'h00;
		ca2_ctl = pcr_q[3:1];
		cb2_ctl = pcr_q[7:5];
		in_b = acr_q[1] ? latb_q : pb_q;
		in_a = (acr_q[0] && rs_q == REG_ORA) ? lata_q : pa_q;
		case (op_q)
			OP_READ: begin
				case (rs_q)
					REG_ORB: begin
						rd_n = (orb_q & ddrb_q) | (in_b & ~ddrb_q);
						ifr_n[FLAG_CB1] = 1'b0; ifr_n[FLAG_CB2] = 1'b0;
					end
					REG_ORA, REG_ORA_NH: begin
						rd_n = (ora_q & ddra_q) | (in_a & ~ddra_q);
						if (rs_q == REG_ORA) begin
							ifr_n[FLAG_CA1] = 1'b0; ifr_n[FLAG_CA2] = 1'b0;
						end
					end
					REG_DDRB: rd_n = ddrb_q;
					REG_DDRA: rd_n = ddra_q;
					REG_T1CL: begin rd_n = t1c_q[7:0]; ifr_n[FLAG_T1] = 1'b0; end
					REG_T1CH: rd_n = t1c_q[15:8];
					REG_T1LL: rd_n = t1l_q[7:0];
					REG_T1LH: rd_n = t1l_q[15:8];
					REG_T2CL: begin rd_n = t2c_q[7:0]; ifr_n[FLAG_T2] = 1'b0; end
					REG_T2CH: rd_n = t2c_q[15:8];
					REG_SR: begin rd_n = sr_q; ifr_n[FLAG_SR] = 1'b0; end
					REG_ACR: rd_n = acr_q;
					REG_PCR: rd_n = pcr_q;
					REG_IFR: rd_n = {|(ifr_q & ier_q), ifr_q};
					default: rd_n = {1'b1, ier_q};
				endcase
			end
			OP_WRITE: begin
				case (rs_q)
					REG_ORB: begin
						orb_n = wd_q;
						ifr_n[FLAG_CB1] = 1'b0; ifr_n[FLAG_CB2] = 1'b0;
						cb2_n = drive(cb2_q, cb2_ctl);
					end
					REG_ORA: begin
						ora_n = wd_q;
						ifr_n[FLAG_CA1] = 1'b0; ifr_n[FLAG_CA2] = 1'b0;
						ca2_n = drive(ca2_q, ca2_ctl);
					end
					REG_ORA_NH: ora_n = wd_q;
					REG_DDRB: ddrb_n = wd_q;
					REG_DDRA: ddra_n = wd_q;
					REG_T1CL, REG_T1LL: t1l_n = {t1l_q[15:8], wd_q};
					REG_T1CH: begin
						t1l_n = {wd_q, t1l_q[7:0]};
						t1c_n = {wd_q, t1l_q[7:0]};
						t1act_n = 1'b1;
						ifr_n[FLAG_T1] = 1'b0;
						if (acr_q[7]) pb7_n = 1'b1;
					end
					REG_T1LH: begin
						t1l_n = {wd_q, t1l_q[7:0]};
						ifr_n[FLAG_T1] = 1'b0;
					end
					REG_T2CL: t2ll_n = wd_q;
					REG_T2CH: begin
						t2c_n = {wd_q, t2ll_q};
						t2act_n = 1'b1;
						ifr_n[FLAG_T2] = 1'b0;
					end
					REG_SR: begin sr_n = wd_q; ifr_n[FLAG_SR] = 1'b0; end
					REG_ACR: acr_n = wd_q;
					REG_PCR: begin
						pcr_n = wd_q;
						ca2_n = drive(ca2_q, wd_q[3:1]);
						cb2_n = drive(cb2_q, wd_q[7:5]);
					end
					REG_IFR: ifr_n = ifr_q & ~wd_q[6:0];
					default: ier_n = wd_q[7] ? (ier_q | wd_q[6:0]) : (ier_q & ~wd_q[6:0]);
				endcase
			end
			OP_TICK: begin
				if (t1act_q) begin
					if (t1c_q == 16'd0) begin
						ifr_n[FLAG_T1] = 1'b1;
						t1c_n = acr_q[6] ? t1l_q : TIMER_MAX;
						if (acr_q[7]) pb7_n = !pb7_q;
					end else t1c_n = t1c_q - 16'd1;
				end
				if (t2act_q) begin
					if (t2c_q == 16'd0) begin
						ifr_n[FLAG_T2] = 1'b1;
						t2act_n = 1'b0;
						t2c_n = TIMER_MAX;
					end else t2c_n = t2c_q - 16'd1;
				end
			end
			OP_CA1: begin
				ca1_n = lvl_q;
				if (pcr_q[0] ? (!ca1_q && lvl_q) : (ca1_q && !lvl_q)) begin
					ifr_n[FLAG_CA1] = 1'b1;
					if (acr_q[0]) lata_n = pa_q;
				end
			end
			OP_CA2: begin
				if (!ca2_ctl[2]) begin
					ca2_n = lvl_q;
					if (pcr_q[2] ? (!ca2_q && lvl_q) : (ca2_q && !lvl_q))
						ifr_n[FLAG_CA2] = 1'b1;
				end
			end
			OP_CB1: begin
				cb1_n = lvl_q;
				if (pcr_q[4] ? (!cb1_q && lvl_q) : (cb1_q && !lvl_q)) begin
					ifr_n[FLAG_CB1] = 1'b1;
					if (acr_q[1]) latb_n = pb_q;
				end
			end
			OP_CB2: begin
				if (!cb2_ctl[2]) begin
					cb2_n = lvl_q;
					if (pcr_q[6] ? (!cb2_q && lvl_q) : (cb2_q && !lvl_q))
						ifr_n[FLAG_CB2] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ora_q <= '0; orb_q <= '0; ddra_q <= '0; ddrb_q <= '0;
			sr_q <= '0; acr_q <= '0; pcr_q <= '0; t2ll_q <= 8'hFF;
			lata_q <= '0; latb_q <= '0;
			t1c_q <= TIMER_MAX; t1l_q <= TIMER_MAX; t2c_q <= TIMER_MAX;
			t1act_q <= 1'b0; t2act_q <= 1'b0; pb7_q <= 1'b0;
			ifr_q <= '0; ier_q <= '0;
			ca1_q <= 1'b0; ca2_q <= 1'b0; cb1_q <= 1'b0; cb2_q <= 1'b0;
			rd_q <= '0;
		end else if (cmd.exec) begin
			ora_q <= ora_n; orb_q <= orb_n; ddra_q <= ddra_n; ddrb_q <= ddrb_n;
			sr_q <= sr_n; acr_q <= acr_n; pcr_q <= pcr_n; t2ll_q <= t2ll_n;
			lata_q <= lata_n; latb_q <= latb_n;
			t1c_q <= t1c_n; t1l_q <= t1l_n; t2c_q <= t2c_n;
			t1act_q <= t1act_n; t2act_q <= t2act_n; pb7_q <= pb7_n;
			ifr_q <= ifr_n; ier_q <= ier_n;
			ca1_q <= ca1_n; ca2_q <= ca2_n; cb1_q <= cb1_n; cb2_q <= cb2_n;
			rd_q <= rd_n;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data <= rd_q;
			irq <= |(ifr_q & ier_q);
			port_a_out <= ora_q & ddra_q;
			port_b_out <= orb_q & ddrb_q;
			pb7_level <= pb7_q;
			ca2_level <= ca2_q;
			cb2_level <= cb2_q;
		end
	end

	a_t2_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_TICK && t2act_q && t2c_q == 16'd0) |=> !t2act_q)
		else $error("timer 2 kept running");
	a_t1_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_TICK && t1act_q && t1c_q == 16'd0) |=> ifr_q[FLAG_T1])
		else $error("timer 1 flag missing");
	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.exec) |=> $stable(ifr_q) && $stable(t1c_q))
		else $error("state changed outside exec");

endmodule

FILE: dv/tb_versatile_interface_adapter_core.sv
// Testbench for versatile_interface_adapter_core: drives bus, tick and line
// requests and checks every result against an in-bench adapter predictor.
// Depends on via_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_versatile_interface_adapter_core;
	import via_pkg::*;

	typedef struct packed {
		logic [7:0] rdata;
		logic irq;
		logic [7:0] pa_out;
		logic [7:0] pb_out;
		logic pb7;
		logic ca2;
		logic cb2;
	} via_result_t;

	// Scoreboard: adapter state shadow plus queue of pending results
	class via_scoreboard;
		logic [7:0] ora, orb, ddra, ddrb, sr_byte, acr, pcr, lat_a, lat_b, t2_lo;
		logic [15:0] t1_cnt, t1_reload, t2_cnt;
		logic t1_run, t2_run, pb7, ca1, ca2, cb1, cb2;
		logic [6:0] ifr, ier;
		via_result_t pending[$];
		int errors;

		function void clear();
			ora = 0; orb = 0; ddra = 0; ddrb = 0; sr_byte = 0; acr = 0; pcr = 0;
			lat_a = 0; lat_b = 0; t2_lo = 8'hFF;
			t1_cnt = TIMER_MAX; t1_reload = TIMER_MAX; t2_cnt = TIMER_MAX;
			t1_run = 0; t2_run = 0; pb7 = 0; ca1 = 0; ca2 = 0; cb1 = 0; cb2 = 0;
			ifr = 0; ier = 0; errors = 0;
			pending.delete();
		endfunction

		function void drive_out(ref logic line, input logic [2:0] mode);
			if (mode == 3'd5 || mode == 3'd6)
				line = 0;
			else if (mode == 3'd7)
				line = 1;
		endfunction

		// Returns 1 on the selected edge, and updates the stored level
		function logic edge_hit(ref logic line, input logic lvl, input logic rising);
			logic old;
			old = line;
			line = lvl;
			return rising ? (!old && lvl) : (old && !lvl);
		endfunction

		function logic [7:0] bus_read(via_reg_t r, logic [7:0] pa, logic [7:0] pb);
			logic [7:0] v, src;
			v = 0;
			case (r)
				REG_ORB: begin
					src = acr[1] ? lat_b : pb;
					v = (orb & ddrb) | (src & ~ddrb);
					ifr[FLAG_CB1] = 0; ifr[FLAG_CB2] = 0;
				end
				REG_ORA, REG_ORA_NH: begin
					src = (acr[0] && r == REG_ORA) ? lat_a : pa;
					v = (ora & ddra) | (src & ~ddra);
					if (r == REG_ORA) begin
						ifr[FLAG_CA1] = 0; ifr[FLAG_CA2] = 0;
					end
				end
				REG_DDRB: v = ddrb;
				REG_DDRA: v = ddra;
				REG_T1CL: begin
					v = t1_cnt[7:0]; ifr[FLAG_T1] = 0;
				end
				REG_T1CH: v = t1_cnt[15:8];
				REG_T1LL: v = t1_reload[7:0];
				REG_T1LH: v = t1_reload[15:8];
				REG_T2CL: begin
					v = t2_cnt[7:0]; ifr[FLAG_T2] = 0;
				end
				REG_T2CH: v = t2_cnt[15:8];
				REG_SR: begin
					v = sr_byte; ifr[FLAG_SR] = 0;
				end
				REG_ACR: v = acr;
				REG_PCR: v = pcr;
				REG_IFR: v = {|(ifr & ier), ifr};
				default: v = {1'b1, ier};
			endcase
			return v;
		endfunction

		function void bus_write(via_reg_t r, logic [7:0] d);
			case (r)
				REG_ORB: begin
					orb = d; ifr[FLAG_CB1] = 0; ifr[FLAG_CB2] = 0;
					drive_out(cb2, pcr[7:5]);
				end
				REG_ORA: begin
					ora = d; ifr[FLAG_CA1] = 0; ifr[FLAG_CA2] = 0;
					drive_out(ca2, pcr[3:1]);
				end
				REG_ORA_NH: ora = d;
				REG_DDRB: ddrb = d;
				REG_DDRA: ddra = d;
				REG_T1CL, REG_T1LL: t1_reload[7:0] = d;
				REG_T1CH: begin
					t1_reload[15:8] = d; t1_cnt = t1_reload; t1_run = 1;
					ifr[FLAG_T1] = 0;
					if (acr[7]) pb7 = 1;
				end
				REG_T1LH: begin
					t1_reload[15:8] = d; ifr[FLAG_T1] = 0;
				end
				REG_T2CL: t2_lo = d;
				REG_T2CH: begin
					t2_cnt = {d, t2_lo}; t2_run = 1; ifr[FLAG_T2] = 0;
				end
				REG_SR: begin
					sr_byte = d; ifr[FLAG_SR] = 0;
				end
				REG_ACR: acr = d;
				REG_PCR: begin
					pcr = d;
					drive_out(ca2, pcr[3:1]);
					drive_out(cb2, pcr[7:5]);
				end
				REG_IFR: ifr = ifr & ~d[6:0];
				default: ier = d[7] ? (ier | d[6:0]) : (ier & ~d[6:0]);
			endcase
		endfunction

		function void tick();
			if (t1_run) begin
				if (t1_cnt == 0) begin
					ifr[FLAG_T1] = 1;
					t1_cnt = acr[6] ? t1_reload : TIMER_MAX;
					if (acr[7]) pb7 = !pb7;
				end else
					t1_cnt--;
			end
			if (t2_run) begin
				if (t2_cnt == 0) begin
					ifr[FLAG_T2] = 1; t2_run = 0; t2_cnt = TIMER_MAX;
				end else
					t2_cnt--;
			end
		endfunction

		// Accepted request: advance the shadow and queue the expected result
		function void note_request(logic [2:0] op, logic [3:0] rs, logic [7:0] wd,
				logic lvl, logic [7:0] pa, logic [7:0] pb);
			via_result_t res;
			res.rdata = 0;
			case (via_op_t'(op))
				OP_READ: res.rdata = bus_read(via_reg_t'(rs), pa, pb);
				OP_WRITE: bus_write(via_reg_t'(rs), wd);
				OP_TICK: tick();
				OP_CA1: if (edge_hit(ca1, lvl, pcr[0])) begin
					ifr[FLAG_CA1] = 1;
					if (acr[0]) lat_a = pa;
				end
				OP_CA2: if (pcr[3:1] < 4 && edge_hit(ca2, lvl, pcr[2]))
					ifr[FLAG_CA2] = 1;
				OP_CB1: if (edge_hit(cb1, lvl, pcr[4])) begin
					ifr[FLAG_CB1] = 1;
					if (acr[1]) lat_b = pb;
				end
				OP_CB2: if (pcr[7:5] < 4 && edge_hit(cb2, lvl, pcr[6]))
					ifr[FLAG_CB2] = 1;
				default: ;
			endcase
			res.irq = |(ifr & ier);
			res.pa_out = ora & ddra;
			res.pb_out = orb & ddrb;
			res.pb7 = pb7;
			res.ca2 = ca2;
			res.cb2 = cb2;
			pending.push_back(res);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch: %s got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(via_result_t got);
			via_result_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.rdata !== want.rdata) report("read_data", got.rdata, want.rdata);
			if (got.irq !== want.irq) report("irq", got.irq, want.irq);
			if (got.pa_out !== want.pa_out) report("port_a_out", got.pa_out, want.pa_out);
			if (got.pb_out !== want.pb_out) report("port_b_out", got.pb_out, want.pb_out);
			if (got.pb7 !== want.pb7) report("pb7_level", got.pb7, want.pb7);
			if (got.ca2 !== want.ca2) report("ca2_level", got.ca2, want.ca2);
			if (got.cb2 !== want.cb2) report("cb2_level", got.cb2, want.cb2);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [2:0] opcode = 0;
	logic [3:0] reg_select = 0;
	logic [7:0] write_data = 0, port_a_pins = 0, port_b_pins = 0;
	logic line_level = 0;
	logic [7:0] read_data, port_a_out, port_b_out;
	logic irq, pb7_level, ca2_level, cb2_level;

	via_scoreboard board;
	bit calm = 0;
	bit hold_rx = 0;
	bit feed_done = 0;

	versatile_interface_adapter_core dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Send one request; optional idle burst first, then hold until accepted
	task automatic send(via_op_t op, via_reg_t rs, logic [7:0] wd, logic lvl,
			logic [7:0] pa, logic [7:0] pb);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		reg_select <= rs;
		write_data <= wd;
		line_level <= lvl;
		port_a_pins <= pa;
		port_b_pins <= pb;
		do @(posedge clk); while (in_stall);
		board.note_request(op, rs, wd, lvl, pa, pb);
		@(negedge clk);
	endtask

	task automatic wr(via_reg_t rs, logic [7:0] d);
		send(OP_WRITE, rs, d, $urandom_range(0, 1), $urandom, $urandom);
	endtask

	task automatic rd(via_reg_t rs);
		send(OP_READ, rs, $urandom, $urandom_range(0, 1), $urandom, $urandom);
	endtask

	task automatic line(via_op_t op, logic lvl);
		send(op, REG_ORB, $urandom, lvl, $urandom, $urandom);
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			rd(via_reg_t'($urandom_range(0, 15)));
		else if (pick < 55)
			wr(via_reg_t'($urandom_range(0, 15)), $urandom);
		else if (pick < 80)
			send(OP_TICK, via_reg_t'($urandom), $urandom, $urandom, $urandom, $urandom);
		else if (pick < 98)
			line(via_op_t'($urandom_range(3, 6)), $urandom_range(0, 1));
		else
			send(OP_NONE, via_reg_t'($urandom), $urandom, $urandom, $urandom, $urandom);
	endtask

	// Result side: random stalls, checks on accept
	always @(negedge clk) begin
		if (hold_rx)
			out_stall <= 1;
		else if (!calm && $urandom_range(0, 5) == 0)
			out_stall <= 1;
		else
			out_stall <= 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{read_data, irq, port_a_out, port_b_out,
				pb7_level, ca2_level, cb2_level});
	end

	// Long receiver hold-off to back up the pipe
	initial begin
		wait (arst_n);
		repeat (300) @(negedge clk);
		hold_rx = 1;
		repeat (60) @(negedge clk);
		hold_rx = 0;
	end

	initial begin
		int i, n;
		board = new();
		board.clear();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: register map, extremes, timers, edges, output modes
		for (i = 0; i < 16; i++)
			rd(via_reg_t'(i));
		wr(REG_DDRA, 8'hFF); wr(REG_ORA, 8'hA5); wr(REG_DDRB, 8'h0F);
		wr(REG_ORB, 8'hFF);
		wr(REG_IER, 8'hFF);
		wr(REG_ACR, 8'hC3);
		wr(REG_T1CL, 8'h02); wr(REG_T1CH, 8'h00);
		wr(REG_T2CL, 8'h01); wr(REG_T2CH, 8'h00);
		repeat (8) send(OP_TICK, REG_ORB, 0, 0, 0, 0);
		rd(REG_IFR); rd(REG_T1CL); rd(REG_T2CL);
		wr(REG_PCR, 8'hEE);
		wr(REG_PCR, 8'h15);
		line(OP_CA1, 1); line(OP_CB1, 1); line(OP_CA2, 1); line(OP_CB2, 1);
		rd(REG_ORA); rd(REG_ORB); rd(REG_ORA_NH);
		wr(REG_IFR, 8'h7F); wr(REG_IER, 8'h7F);
		wr(REG_PCR, 8'hCC); wr(REG_ORA, 8'h00); wr(REG_ORB, 8'h00);
		wr(REG_SR, 8'h5A); rd(REG_SR); wr(REG_T1LH, 8'h00); wr(REG_T1LL, 8'h03);

		// Random: mostly short timer loads so expiries happen often
		for (n = 0; n < 560; n++) begin
			if (n == 490) calm = 1;
			if ($urandom_range(0, 19) == 0) begin
				wr(REG_ACR, $urandom);
				wr(REG_T1CL, $urandom_range(0, 6));
				wr(REG_T1CH, $urandom_range(0, 3) == 0 ? $urandom : 8'h00);
				wr(REG_T2CL, $urandom_range(0, 6));
				wr(REG_T2CH, 8'h00);
				wr(REG_PCR, $urandom);
				wr(REG_IER, $urandom);
			end else
				random_request();
		end
		in_valid <= 0;
		feed_done = 1;
	end

	// End of run: drain, let the pipe settle, then verdict
	initial begin
		int k;
		wait (feed_done);
		k = 0;
		while (board.pending.size() != 0 && k < 10000) begin
			@(posedge clk);
			k++;
		end
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#200000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
